// ----- src/mm64_pkg.sv -----
package mm64_pkg;

  // mixing multiplier and shift of the 64-bit murmur hash
  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT = 47;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_LEN_W,
    S_MIX,
    S_K1,
    S_K1_W,
    S_K2,
    S_K2_W,
    S_H,
    S_H_W,
    S_FIN,
    S_FIN_W,
    S_OUT
  } seq_state_e;

  // low byte mask for a tail of 1 to 7 bytes
  function automatic logic [63:0] tail_mask(input logic [2:0] nbytes);
    logic [63:0] m;
    begin
      case (nbytes)
        3'd1:    m = 64'h0000_0000_0000_00ff;
        3'd2:    m = 64'h0000_0000_0000_ffff;
        3'd3:    m = 64'h0000_0000_00ff_ffff;
        3'd4:    m = 64'h0000_0000_ffff_ffff;
        3'd5:    m = 64'h0000_00ff_ffff_ffff;
        3'd6:    m = 64'h0000_ffff_ffff_ffff;
        3'd7:    m = 64'h00ff_ffff_ffff_ffff;
        default: m = 64'h0;
      endcase
      return m;
    end
  endfunction

  // x ^ (x >> 47)
  function automatic logic [63:0] xorshift(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

// ----- src/mm64_mul.sv -----
module mm64_mul
  import mm64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] operand_i,
  output logic        done_o,
  output logic [63:0] product_o
);

  // operand * MIX_MUL mod 2^64 in two steps:
  // low x low product first, then the two truncated cross products
  logic [31:0] a_hi_q;
  logic [31:0] a_lo_q;
  logic [63:0] p0_q;
  logic [63:0] p0_d;
  logic [31:0] cross_a;
  logic [31:0] cross_b;
  logic [31:0] cross_sum;
  logic        ph_q;
  logic        done_q;
  logic [63:0] prod_q;

  assign p0_d      = operand_i[31:0] * MIX_MUL[31:0];
  assign cross_a   = 32'(a_hi_q * MIX_MUL[31:0]);
  assign cross_b   = 32'(a_lo_q * MIX_MUL[63:32]);
  assign cross_sum = cross_a + cross_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ph_q   <= start_i;
      done_q <= ph_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_hi_q <= operand_i[63:32];
      a_lo_q <= operand_i[31:0];
      p0_q   <= p0_d;
    end
    if (ph_q) begin
      prod_q <= p0_q + {cross_sum, 32'h0};
    end
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

// ----- src/murmur64a_stream_hash.sv -----
// murmur64a_stream_hash: streaming 64-bit murmur hash (64a variant)
//
// input stream: one beat per 64-bit key word; tuser marks the first word of
// a key (which reloads the accumulator from hash_seed and key_length), tlast
// marks the last word (which runs the avalanche and emits one hash beat)
// output stream: one 64-bit hash beat per key, held in an output register
// config: cfg_we_i writes the 32-bit seed, used at the next first word
//
// every 64x64 product runs on one shared multiplier, in the steps issue,
// cross terms and result. work per input beat: a full word runs the two
//   key products and the hash product, a tail word the hash product, an
//   empty word none; a first word adds the length product, a last word
//   the avalanche product and the output load
// the input is not ready while a word is in work
// the output register frees the input side: a new key can start while the
// hash waits; only a second finished hash waits for the receiver to take
// the first one, holding the sequencer until then
// reset clears the seed and the accumulator and empties the output
module murmur64a_stream_hash
  import mm64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,    // hash_seed
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // key_length[15:0], data_word[79:16],
                                      // valid_bytes[83:80], zero [87:84]
  input  logic        s_axis_tuser,   // first_word
  input  logic        s_axis_tlast,   // last_word
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // hash_value
);

  seq_state_e  state_q, state_d;
  logic [31:0] seed_q;
  logic [63:0] h_q, h_d;
  logic [63:0] k_q, k_d;
  logic [63:0] word_q;
  logic [15:0] len_q;
  logic [3:0]  nb_q;
  logic        last_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_q, out_d;

  logic        in_beat;
  logic        mul_start;
  logic [63:0] mul_operand;
  logic        mul_done;
  logic [63:0] mul_product;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  mm64_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .operand_i (mul_operand),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_start   = 1'b0;
    mul_operand = h_q;
    case (state_q)
      S_LEN: begin
        mul_start   = 1'b1;
        mul_operand = {48'h0, len_q};
      end
      S_K1: begin
        mul_start   = 1'b1;
        mul_operand = word_q;
      end
      S_K2: begin
        mul_start   = 1'b1;
        mul_operand = k_q;
      end
      S_H: begin
        mul_start   = 1'b1;
        mul_operand = h_q;
      end
      S_FIN: begin
        mul_start   = 1'b1;
        mul_operand = xorshift(h_q);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    k_d         = k_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d = s_axis_tuser ? S_LEN : S_MIX;
        end
      end
      S_LEN:   state_d = S_LEN_W;
      S_LEN_W: begin
        if (mul_done) begin
          h_d     = {32'h0, seed_q} ^ mul_product;
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        if (nb_q >= 4'd8) begin
          state_d = S_K1;
        end else if (nb_q != 4'd0) begin
          h_d     = h_q ^ (word_q & tail_mask(nb_q[2:0]));
          state_d = S_H;
        end else begin
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_K1:   state_d = S_K1_W;
      S_K1_W: begin
        if (mul_done) begin
          k_d     = xorshift(mul_product);
          state_d = S_K2;
        end
      end
      S_K2:   state_d = S_K2_W;
      S_K2_W: begin
        if (mul_done) begin
          h_d     = h_q ^ mul_product;
          state_d = S_H;
        end
      end
      S_H:   state_d = S_H_W;
      S_H_W: begin
        if (mul_done) begin
          h_d     = mul_product;
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_FIN:   state_d = S_FIN_W;
      S_FIN_W: begin
        if (mul_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // product stays in the multiplier until the output slot frees up
        if (!out_valid_q || m_axis_tready) begin
          out_d       = xorshift(mul_product);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= 32'h0;
      h_q         <= 64'h0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    out_q <= out_d;
    if (in_beat) begin
      len_q   <= s_axis_tdata[15:0];
      word_q  <= s_axis_tdata[79:16];
      nb_q    <= s_axis_tdata[83:80];
      last_q  <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
